// ----- hw/rtl/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types, codes and helpers for the string unescape decoder
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ErrW   = 2;
  localparam int unsigned HexCntW = 2;

  localparam logic [ByteW-1:0] ChQuote     = 8'h22;
  localparam logic [ByteW-1:0] ChBackslash = 8'h5C;
  localparam logic [ByteW-1:0] ChSlash     = 8'h2F;
  localparam logic [ByteW-1:0] ChLowerB    = 8'h62;
  localparam logic [ByteW-1:0] ChLowerF    = 8'h66;
  localparam logic [ByteW-1:0] ChLowerN    = 8'h6E;
  localparam logic [ByteW-1:0] ChLowerR    = 8'h72;
  localparam logic [ByteW-1:0] ChLowerT    = 8'h74;
  localparam logic [ByteW-1:0] ChLowerU    = 8'h75;

  localparam logic [ByteW-1:0] ChBs  = 8'h08;
  localparam logic [ByteW-1:0] ChFf  = 8'h0C;
  localparam logic [ByteW-1:0] ChLf  = 8'h0A;
  localparam logic [ByteW-1:0] ChCr  = 8'h0D;
  localparam logic [ByteW-1:0] ChTab = 8'h09;

  localparam logic [HexCntW-1:0] HexLast = 2'd3;

  localparam logic [ErrW-1:0] ErrNone  = 2'd0;
  localparam logic [ErrW-1:0] ErrQuote = 2'd1;
  localparam logic [ErrW-1:0] ErrHex   = 2'd2;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_STRING  = 4'b0010,
    MODE_ESCAPE  = 4'b0100,
    MODE_UNICODE = 4'b1000
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [HexCntW-1:0] hex_count;
    logic [ByteW-1:0]   hex_low_bits;
  } state_t;

  typedef struct packed {
    logic             has_char;
    logic [ByteW-1:0] out_byte;
    logic             string_end;
    logic [ErrW-1:0]  error_code;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_value(input logic [ByteW-1:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h41 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/jsu_step.sv -----
// ----------------------------------------------------------------------------
// jsu_step
// next-state and result logic for one input byte of the decoder
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_step (
  input  wire logic [jsu_pkg::ByteW-1:0] byte_i,
  input  wire jsu_pkg::state_t           state_i,
  output jsu_pkg::state_t                state_o,
  output jsu_pkg::result_t               result_o
);

  jsu_pkg::hex_t             hex;
  logic [jsu_pkg::ByteW-1:0] low_nxt;

  assign hex     = jsu_pkg::hex_value(byte_i);
  assign low_nxt = {state_i.hex_low_bits[3:0], hex.value};

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    case (state_i.mode)
      jsu_pkg::MODE_STRING: begin
        if (byte_i == jsu_pkg::ChBackslash) begin
          state_o.mode = jsu_pkg::MODE_ESCAPE;
        end else if (byte_i == jsu_pkg::ChQuote) begin
          state_o.mode        = jsu_pkg::MODE_IDLE;
          result_o.string_end = 1'b1;
        end else begin
          result_o.has_char = 1'b1;
          result_o.out_byte = byte_i;
        end
      end
      jsu_pkg::MODE_ESCAPE: begin
        result_o.has_char = 1'b1;
        case (byte_i)
          jsu_pkg::ChQuote:     result_o.out_byte = jsu_pkg::ChQuote;
          jsu_pkg::ChBackslash: result_o.out_byte = jsu_pkg::ChBackslash;
          jsu_pkg::ChSlash:     result_o.out_byte = jsu_pkg::ChSlash;
          jsu_pkg::ChLowerB:    result_o.out_byte = jsu_pkg::ChBs;
          jsu_pkg::ChLowerF:    result_o.out_byte = jsu_pkg::ChFf;
          jsu_pkg::ChLowerN:    result_o.out_byte = jsu_pkg::ChLf;
          jsu_pkg::ChLowerR:    result_o.out_byte = jsu_pkg::ChCr;
          jsu_pkg::ChLowerT:    result_o.out_byte = jsu_pkg::ChTab;
          jsu_pkg::ChLowerU: begin
            result_o.has_char     = 1'b0;
            state_o.mode          = jsu_pkg::MODE_UNICODE;
            state_o.hex_count     = '0;
            state_o.hex_low_bits  = '0;
          end
          default: result_o.has_char = 1'b0;
        endcase
        if (result_o.has_char) begin
          state_o.mode = jsu_pkg::MODE_STRING;
        end
      end
      jsu_pkg::MODE_UNICODE: begin
        if (!hex.ok) begin
          result_o.error_code  = jsu_pkg::ErrHex;
          state_o.mode         = jsu_pkg::MODE_IDLE;
          state_o.hex_count    = '0;
          state_o.hex_low_bits = '0;
        end else if (state_i.hex_count == jsu_pkg::HexLast) begin
          result_o.has_char    = 1'b1;
          result_o.out_byte    = low_nxt;
          state_o.mode         = jsu_pkg::MODE_STRING;
          state_o.hex_count    = '0;
          state_o.hex_low_bits = '0;
        end else begin
          state_o.hex_count    = state_i.hex_count + 2'd1;
          state_o.hex_low_bits = low_nxt;
        end
      end
      default: begin
        // idle: waiting for the opening quote
        if (byte_i == jsu_pkg::ChQuote) begin
          state_o.mode = jsu_pkg::MODE_STRING;
        end else begin
          state_o.mode        = jsu_pkg::MODE_IDLE;
          result_o.error_code = jsu_pkg::ErrQuote;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/json_string_unescape.sv -----
// ----------------------------------------------------------------------------
// json_string_unescape
// decodes one quoted string literal, one raw byte per beat
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_byte carries raw bytes, starting with the
// opening quote. Every accepted beat gives exactly one result beat on
// out_valid/out_stall with has_char, out_byte, string_end and error_code.
// A beat is taken when valid is high and stall is low.
// An accepted byte is held in the input register, decoded against the mode
// register, and its result is held in the result register, which drives the
// outputs. Throughput is one byte per cycle while the receiver does not stall,
// set by the single decode pass from input register to result register.
// Reset puts the decoder in idle, waiting for an opening quote, and empties
// both registers. While the receiver stalls, the result register holds its
// beat, one more byte is taken into the input register, and then in_stall
// rises until the result is taken.
// Errors (missing opening quote, bad hex digit) return the decoder to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [jsu_pkg::ByteW-1:0]   in_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_has_char,
  output logic [jsu_pkg::ByteW-1:0]        out_byte,
  output logic                             out_string_end,
  output logic [jsu_pkg::ErrW-1:0]         out_error_code
);

  logic                      in_valid_r;
  logic [jsu_pkg::ByteW-1:0] in_byte_r;
  logic                      out_valid_r;
  jsu_pkg::result_t          result_r;
  jsu_pkg::state_t           state_r;
  jsu_pkg::state_t           state_nxt;
  jsu_pkg::result_t          result_nxt;
  logic                      advance;
  logic                      in_take;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  jsu_step u_step (
    .byte_i   (in_byte_r),
    .state_i  (state_r),
    .state_o  (state_nxt),
    .result_o (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{mode: jsu_pkg::MODE_IDLE, hex_count: '0, hex_low_bits: '0};
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_byte;
    end
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_has_char   = result_r.has_char;
  assign out_byte       = result_r.out_byte;
  assign out_string_end = result_r.string_end;
  assign out_error_code = result_r.error_code;

  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.string_end |->
      !result_r.has_char && result_r.error_code == jsu_pkg::ErrNone)
    else $error("string end beat carries a byte or an error");

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.string_end |-> state_r.mode == jsu_pkg::MODE_IDLE)
    else $error("decoder not idle after closing quote");

  a_hex_err_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.error_code == jsu_pkg::ErrHex |->
      state_r.mode == jsu_pkg::MODE_IDLE && state_r.hex_count == '0 &&
      state_r.hex_low_bits == '0)
    else $error("hex error did not clear the unicode state");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_byte_r))
    else $error("held input byte lost while result stalled");

endmodule

`default_nettype wire
